>>> hw/rtl/nms_pkg.sv
// Package for the natural merge argsort unit.
// Holds widths, the controller state type and the command and status structs.
// No dependencies.
`default_nettype none

package nms_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int KEY_W            = 32;
   localparam int TAG_W            = 16;
   localparam int WORD_W           = KEY_W + TAG_W;

   // Controller states.
   typedef enum logic [3:0] {
      S_LOAD,
      S_FIN,
      S_PINIT,
      S_BMID,
      S_BHI,
      S_BHIW,
      S_MRD,
      S_MWR,
      S_BWR,
      S_PEND,
      S_ERD,
      S_EOUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_fire;
      logic fin;
      logic pinit;
      logic bmid;
      logic bhi;
      logic bhiw;
      logic mwr;
      logic bwr;
      logic pend;
      logic emit_mode;
      logic emit_fire;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic single_run;
      logic pair_done;
      logic last_pair;
      logic next_single;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/natural_merge_argsort_unit.sv
// Top level of the natural merge argsort unit.
// Instantiates nms_ctrl and nms_dp. Depends on nms_pkg.
// Loading accepts one element per cycle; the set ends with tlast.
// Sorting makes ceil(log2(runs)) passes, each bound by the single
// compare-and-write step over the two-read element bank. Results are read and
// offered one at a time. Reset is synchronous and active high;
// it clears the controller and set counters, the stores need no clearing.
`default_nettype none

module natural_merge_argsort_unit #(
   parameter int MAX_ELEMENTS = nms_pkg::MAX_ELEMENTS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire [nms_pkg::WORD_W-1:0]   req_tdata,  // key[31:0], tag[47:32]
   input  wire                         req_tlast,  // last_in
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [nms_pkg::WORD_W-1:0]  rsp_tdata,  // sorted_key[31:0], sorted_tag[47:32]
   output logic                        rsp_tlast,  // last_out
   output logic                        rsp_tuser   // overflow
);
   import nms_pkg::*;

   cmd_type    cmd;
   status_type status;

   nms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nms_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .in_word  (req_tdata),
      .out_word (rsp_tdata),
      .out_ovf  (rsp_tuser)
   );

   assign rsp_tlast = status.emit_last;

   // No input transfer while results are offered.
   a_no_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during result output");

   // After the final result the block returns to loading.
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block did not return to loading");

   // Within a set, the block keeps emitting after a non-final result.
   a_stay_in_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> !req_tready)
      else $error("output ended before the final result");

endmodule

`default_nettype wire

>>> hw/rtl/nms_ctrl.sv
// Controller state machine of the natural merge argsort unit.
// Sequences loading, merge passes and result output. Depends on nms_pkg.
`default_nettype none

module nms_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   input  wire                 req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  nms_pkg::status_type status,
   output nms_pkg::cmd_type    cmd
);
   import nms_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_fire;
   logic      rsp_fire;

   assign req_fire = req_tvalid && (state_ff == S_LOAD);
   assign rsp_fire = rsp_tready && (state_ff == S_EOUT);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_fire && req_tlast) state_in = S_FIN;
         end
         S_FIN: begin
            state_in = status.single_run ? S_ERD : S_PINIT;
         end
         S_PINIT: state_in = S_BMID;
         S_BMID:  state_in = S_BHI;
         S_BHI:   state_in = S_BHIW;
         S_BHIW:  state_in = S_MRD;
         S_MRD: begin
            state_in = status.pair_done ? S_BWR : S_MWR;
         end
         S_MWR:   state_in = S_MRD;
         S_BWR: begin
            state_in = status.last_pair ? S_PEND : S_BMID;
         end
         S_PEND: begin
            state_in = status.next_single ? S_ERD : S_PINIT;
         end
         S_ERD:   state_in = S_EOUT;
         S_EOUT: begin
            if (rsp_fire) state_in = status.emit_last ? S_LOAD : S_ERD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready    = (state_ff == S_LOAD);
      rsp_tvalid    = (state_ff == S_EOUT);
      cmd           = '0;
      cmd.load_fire = req_fire;
      cmd.fin       = (state_ff == S_FIN);
      cmd.pinit     = (state_ff == S_PINIT);
      cmd.bmid      = (state_ff == S_BMID);
      cmd.bhi       = (state_ff == S_BHI);
      cmd.bhiw      = (state_ff == S_BHIW);
      cmd.mwr       = (state_ff == S_MWR);
      cmd.bwr       = (state_ff == S_BWR);
      cmd.pend      = (state_ff == S_PEND);
      cmd.emit_mode = (state_ff == S_ERD) || (state_ff == S_EOUT);
      cmd.emit_fire = rsp_fire;
   end

endmodule

`default_nettype wire

>>> hw/rtl/nms_dp.sv
// Datapath of the natural merge argsort unit: two element banks, two bound
// banks, run detection, the merge step and the output path. Depends on nms_pkg.
`default_nettype none

module nms_dp #(
   parameter int MAX_ELEMENTS = nms_pkg::MAX_ELEMENTS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  nms_pkg::cmd_type             cmd,
   output nms_pkg::status_type          status,
   input  wire [nms_pkg::WORD_W-1:0]    in_word,
   output logic [nms_pkg::WORD_W-1:0]   out_word,
   output logic                         out_ovf
);
   import nms_pkg::*;

   localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

   // Element and bound banks, used ping-pong between passes.
   logic [WORD_W-1:0] dat0 [MAX_ELEMENTS];
   logic [WORD_W-1:0] dat1 [MAX_ELEMENTS];
   logic [CW-1:0]     bnd0 [MAX_ELEMENTS+1];
   logic [CW-1:0]     bnd1 [MAX_ELEMENTS+1];

   logic [CW-1:0]     count_ff, runs_ff, emit_ff;
   logic              ovf_ff, src_ff;
   logic [KEY_W-1:0]  prev_ff;
   logic [CW-1:0]     q_ff, lo_ff, mid_ff, hi_ff, i_ff, j_ff, k_ff;
   logic [WORD_W-1:0] d0a_ff, d0b_ff, d1a_ff, d1b_ff;
   logic [CW-1:0]     b0q_ff, b1q_ff;

   logic [WORD_W-1:0] rda, rdb;
   logic [CW-1:0]     bq;
   logic [CW:0]       half_w, mid2, hi2;
   logic [CW-1:0]     half, mid_idx, hi_idx, b_raddr;
   logic [CW-1:0]     addr_a, addr_b;
   logic              take_i;
   logic [KEY_W-1:0]  in_key;

   logic              dw_en, dw_bank;
   logic [CW-1:0]     dw_addr;
   logic [WORD_W-1:0] dw_data;
   logic              bw_en, bw_bank;
   logic [CW-1:0]     bw_addr, bw_data;

   assign in_key = in_word[KEY_W-1:0];
   assign rda    = src_ff ? d1a_ff : d0a_ff;
   assign rdb    = src_ff ? d1b_ff : d0b_ff;
   assign bq     = src_ff ? b1q_ff : b0q_ff;

   // Pair indexes into the bound list of the current pass.
   assign half_w  = ({1'b0, runs_ff} + (CW+1)'(1)) >> 1;
   assign half    = half_w[CW-1:0];
   assign mid2    = {q_ff, 1'b1};
   assign hi2     = {q_ff, 1'b0} + (CW+1)'(2);
   assign mid_idx = (mid2 > {1'b0, runs_ff}) ? runs_ff : mid2[CW-1:0];
   assign hi_idx  = (hi2 > {1'b0, runs_ff}) ? runs_ff : hi2[CW-1:0];
   assign b_raddr = cmd.bmid ? mid_idx : hi_idx;

   // Merge choice: the first run wins on a strictly smaller key or once the second run is used up.
   assign take_i = (i_ff < mid_ff) &&
                   ((j_ff >= hi_ff) ||
                    ($signed(rda[KEY_W-1:0]) < $signed(rdb[KEY_W-1:0])));

   assign addr_a = cmd.emit_mode ? emit_ff : i_ff;
   assign addr_b = j_ff;

   // Write port selection for the element and bound banks.
   always_comb begin
      dw_en   = 1'b0;
      dw_bank = src_ff;
      dw_addr = count_ff;
      dw_data = in_word;
      bw_en   = 1'b0;
      bw_bank = src_ff;
      bw_addr = runs_ff;
      bw_data = count_ff;
      if (cmd.load_fire && (count_ff < MAX_C)) begin
         dw_en = 1'b1;
         if (count_ff == '0) begin
            bw_en   = 1'b1;
            bw_addr = '0;
            bw_data = '0;
         end else if ($signed(in_key) < $signed(prev_ff)) begin
            bw_en = 1'b1;
         end
      end
      if (cmd.fin) begin
         bw_en = 1'b1;
      end
      if (cmd.mwr) begin
         dw_en   = 1'b1;
         dw_bank = ~src_ff;
         dw_addr = k_ff;
         dw_data = take_i ? rda : rdb;
      end
      if (cmd.pinit) begin
         bw_en   = 1'b1;
         bw_bank = ~src_ff;
         bw_addr = '0;
         bw_data = '0;
      end
      if (cmd.bwr) begin
         bw_en   = 1'b1;
         bw_bank = ~src_ff;
         bw_addr = q_ff + CW'(1);
         bw_data = hi_ff;
      end
   end

   // Element banks: one write and two registered reads each.
   always_ff @(posedge clock) begin
      if (dw_en && !dw_bank) dat0[dw_addr[IW-1:0]] <= dw_data;
      if (dw_en && dw_bank)  dat1[dw_addr[IW-1:0]] <= dw_data;
      d0a_ff <= dat0[addr_a[IW-1:0]];
      d0b_ff <= dat0[addr_b[IW-1:0]];
      d1a_ff <= dat1[addr_a[IW-1:0]];
      d1b_ff <= dat1[addr_b[IW-1:0]];
   end

   // Bound banks: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (bw_en && !bw_bank) bnd0[bw_addr] <= bw_data;
      if (bw_en && bw_bank)  bnd1[bw_addr] <= bw_data;
      b0q_ff <= bnd0[b_raddr];
      b1q_ff <= bnd1[b_raddr];
   end

   // Set bookkeeping: count, runs, overflow, bank select and output position.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         runs_ff  <= '0;
         emit_ff  <= '0;
         ovf_ff   <= 1'b0;
         src_ff   <= 1'b0;
      end else begin
         if (cmd.load_fire) begin
            if (count_ff < MAX_C) begin
               count_ff <= count_ff + CW'(1);
               if (count_ff == '0) begin
                  runs_ff <= CW'(1);
               end else if ($signed(in_key) < $signed(prev_ff)) begin
                  runs_ff <= runs_ff + CW'(1);
               end
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.pend) begin
            runs_ff <= half;
            src_ff  <= ~src_ff;
         end
         if (cmd.emit_fire) begin
            if (status.emit_last) begin
               count_ff <= '0;
               runs_ff  <= '0;
               emit_ff  <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               emit_ff <= emit_ff + CW'(1);
            end
         end
      end
   end

   // Merge pointers and pair bounds.
   always_ff @(posedge clock) begin
      if (cmd.load_fire) prev_ff <= in_key;
      if (cmd.pinit) begin
         q_ff  <= '0;
         lo_ff <= '0;
      end
      if (cmd.bhi) mid_ff <= bq;
      if (cmd.bhiw) begin
         hi_ff <= bq;
         i_ff  <= lo_ff;
         j_ff  <= mid_ff;
         k_ff  <= lo_ff;
      end
      if (cmd.mwr) begin
         k_ff <= k_ff + CW'(1);
         if (take_i) i_ff <= i_ff + CW'(1);
         else        j_ff <= j_ff + CW'(1);
      end
      if (cmd.bwr) begin
         lo_ff <= hi_ff;
         q_ff  <= q_ff + CW'(1);
      end
   end

   // Status toward the controller.
   always_comb begin
      status.single_run  = (runs_ff == CW'(1));
      status.pair_done   = (k_ff == hi_ff);
      status.last_pair   = ((q_ff + CW'(1)) == half);
      status.next_single = (half == CW'(1));
      status.emit_last   = ((emit_ff + CW'(1)) == count_ff);
   end

   assign out_word = rda;
   assign out_ovf  = ovf_ff;

endmodule

`default_nettype wire
